[src/assert_macros.svh]
// Assertion macros used by the RTL top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_ALWAYS(lbl, clk, rst, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("assertion failed");
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_ALWAYS(lbl, clk, rst, cond)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

[src/tgbc_pkg.sv]
// Shared types and constants of the tile grid box collision block
package tgbc_pkg;

  localparam int POS_W      = 16;
  localparam int SIZE_W     = 10;
  localparam int TS_W       = 8;
  localparam int MAP_W      = 7;
  localparam int Y_W        = 17;
  localparam int DIV_W      = 17;
  localparam int DIV_LANES  = 4;
  localparam int DIV_CNT_W  = $clog2(DIV_W);
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  // Divider lanes: left column, right column, top row, bottom row
  localparam int LANE_C0 = 0;
  localparam int LANE_C1 = 1;
  localparam int LANE_R0 = 2;
  localparam int LANE_R1 = 3;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_TILE_SIZE    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAP_WIDTH    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAP_HEIGHT   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LANDING_TOL  = 2'd3;

  // Register reset values
  localparam logic [TS_W-1:0]  TILE_SIZE_RST   = 8'd24;
  localparam logic [MAP_W-1:0] MAP_WIDTH_RST   = 7'd64;
  localparam logic [MAP_W-1:0] MAP_HEIGHT_RST  = 7'd64;
  localparam logic [TS_W-1:0]  LANDING_TOL_RST = 8'd4;

  typedef enum logic [2:0] {
    OP_SET   = 3'd0,
    OP_CLEAR = 3'd1,
    OP_PROBE = 3'd2,
    OP_LEFT  = 3'd3,
    OP_RIGHT = 3'd4,
    OP_UP    = 3'd5,
    OP_DOWN  = 3'd6
  } op_t;

  typedef struct packed {
    logic clear_step;
    logic accept;
    logic plan;
    logic read;
    logic eval;
    logic finish;
  } ctrl_cmd_t;

  typedef struct packed {
    logic clear_last;
    logic div_done;
    logic need_read;
    logic scan_last;
  } dp_status_t;

endpackage

[src/tgbc_divider.sv]
// Four-lane bit-serial restoring divider for tile coordinates
module tgbc_divider import tgbc_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [DIV_W-1:0] dividend [DIV_LANES],
  input  logic [TS_W-1:0]  divisor,
  output logic [DIV_W-1:0] quot [DIV_LANES],
  output logic [TS_W-1:0]  rem [DIV_LANES],
  output logic             done
);

  localparam logic [DIV_CNT_W-1:0] CNT_LAST = DIV_CNT_W'(DIV_W - 1);

  logic [DIV_W-1:0]     q_reg [DIV_LANES];
  logic [TS_W-1:0]      r_reg [DIV_LANES];
  logic [DIV_W-1:0]     q_next [DIV_LANES];
  logic [TS_W-1:0]      r_next [DIV_LANES];
  logic [DIV_CNT_W-1:0] cnt;
  logic                 running;

  // One quotient bit per lane per cycle
  always_comb begin
    logic [TS_W:0] partial;
    logic [TS_W:0] diff;
    logic          ge;
    for (int l = 0; l < DIV_LANES; l++) begin
      partial   = {r_reg[l], q_reg[l][DIV_W-1]};
      diff      = partial - {1'b0, divisor};
      ge        = (partial >= {1'b0, divisor});
      r_next[l] = ge ? diff[TS_W-1:0] : partial[TS_W-1:0];
      q_next[l] = {q_reg[l][DIV_W-2:0], ge};
    end
  end

  // Load on start, then shift through all dividend bits
  always_ff @(posedge clk) begin
    if (start) begin
      for (int l = 0; l < DIV_LANES; l++) begin
        q_reg[l] <= dividend[l];
        r_reg[l] <= '0;
      end
    end else if (running) begin
      for (int l = 0; l < DIV_LANES; l++) begin
        q_reg[l] <= q_next[l];
        r_reg[l] <= r_next[l];
      end
    end
  end

  // Step count and completion pulse
  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      cnt     <= '0;
      done    <= 1'b0;
    end else begin
      done <= running && (cnt == CNT_LAST);
      if (start) begin
        running <= 1'b1;
        cnt     <= '0;
      end else if (running) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_LAST) begin
          running <= 1'b0;
        end
      end
    end
  end

  assign quot = q_reg;
  assign rem  = r_reg;

endmodule

[src/tgbc_datapath.sv]
// Datapath: registers, divider, occupancy memory, scan and result logic
module tgbc_datapath import tgbc_pkg::*; #(
  parameter int MAX_COLUMNS = 64,
  parameter int MAX_ROWS    = 64
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic [2:0]            operation,
  input  logic [POS_W-1:0]      pos_x,
  input  logic [POS_W-1:0]      pos_y,
  input  logic [SIZE_W-1:0]     size_x,
  input  logic [SIZE_W-1:0]     size_y,
  input  ctrl_cmd_t             cmd,
  output dp_status_t            status,
  output logic                  done,
  output logic                  hit,
  output logic signed [Y_W-1:0] corrected_y,
  output logic                  occupied,
  output logic                  out_of_range
);

  localparam int RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam logic [RW-1:0] ROW_LAST = RW'(MAX_ROWS - 1);

  // Configuration registers
  logic [TS_W-1:0]  tile_size;
  logic [MAP_W-1:0] map_width;
  logic [MAP_W-1:0] map_height;
  logic [TS_W-1:0]  landing_tolerance;

  always_ff @(posedge clk) begin
    if (rst) begin
      tile_size         <= TILE_SIZE_RST;
      map_width         <= MAP_WIDTH_RST;
      map_height        <= MAP_HEIGHT_RST;
      landing_tolerance <= LANDING_TOL_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_TILE_SIZE:   tile_size         <= cfg_data[TS_W-1:0];
        CFG_MAP_WIDTH:   map_width         <= cfg_data[MAP_W-1:0];
        CFG_MAP_HEIGHT:  map_height        <= cfg_data[MAP_W-1:0];
        CFG_LANDING_TOL: landing_tolerance <= cfg_data[TS_W-1:0];
        default: ;
      endcase
    end
  end

  logic [TS_W-1:0]   ts_eff;
  logic [SIZE_W-1:0] sx_eff;
  logic [SIZE_W-1:0] sy_eff;
  logic [DIV_W-1:0]  col_lim;
  logic [DIV_W-1:0]  row_lim;

  assign ts_eff  = (tile_size == '0) ? TS_W'(1) : tile_size;
  assign sx_eff  = (size_x == '0) ? SIZE_W'(1) : size_x;
  assign sy_eff  = (size_y == '0) ? SIZE_W'(1) : size_y;
  assign col_lim = (DIV_W'(map_width) < DIV_W'(MAX_COLUMNS)) ?
                   DIV_W'(map_width) : DIV_W'(MAX_COLUMNS);
  assign row_lim = (DIV_W'(map_height) < DIV_W'(MAX_ROWS)) ?
                   DIV_W'(map_height) : DIV_W'(MAX_ROWS);

  // Hold the request fields needed after the divide
  op_t              op_r;
  logic [POS_W-1:0] py_r;

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_r <= op_t'(operation);
      py_r <= pos_y;
    end
  end

  // Divide the box corners by the tile size
  logic [DIV_W-1:0] div_a [DIV_LANES];
  logic [DIV_W-1:0] quot [DIV_LANES];
  logic [TS_W-1:0]  rem [DIV_LANES];

  always_comb begin
    div_a[LANE_C0] = DIV_W'(pos_x);
    div_a[LANE_C1] = DIV_W'(pos_x) + DIV_W'(sx_eff) - DIV_W'(1);
    div_a[LANE_R0] = DIV_W'(pos_y);
    div_a[LANE_R1] = DIV_W'(pos_y) + DIV_W'(sy_eff) - DIV_W'(1);
  end

  tgbc_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.accept),
    .dividend (div_a),
    .divisor  (ts_eff),
    .quot     (quot),
    .rem      (rem),
    .done     (status.div_done)
  );

  // Plan the scan: rows to read, cell mask and range flag
  logic                   need_read;
  logic                   oor_next;
  logic [RW-1:0]          first_row;
  logic [RW-1:0]          last_row_next;
  logic [MAX_COLUMNS-1:0] mask_next;

  always_comb begin
    logic [DIV_W-1:0] c0;
    logic [DIV_W-1:0] c1;
    logic [DIV_W-1:0] r0;
    logic [DIV_W-1:0] r1;
    logic [DIV_W-1:0] sel_col;
    logic [DIV_W-1:0] sel_row;
    logic [DIV_W-1:0] row_cap;
    logic             range_mode;
    c0            = quot[LANE_C0];
    c1            = quot[LANE_C1];
    r0            = quot[LANE_R0];
    r1            = quot[LANE_R1];
    row_cap       = row_lim - DIV_W'(1);
    sel_col       = c0;
    sel_row       = r0;
    range_mode    = 1'b0;
    need_read     = 1'b0;
    oor_next      = 1'b0;
    first_row     = r0[RW-1:0];
    last_row_next = r0[RW-1:0];
    case (op_r)
      OP_SET, OP_CLEAR, OP_PROBE: begin
        need_read = (c0 < col_lim) && (r0 < row_lim);
        oor_next  = !need_read;
      end
      OP_LEFT, OP_RIGHT: begin
        sel_col       = (op_r == OP_RIGHT) ? c1 : c0;
        need_read     = (sel_col < col_lim) && (r0 < row_lim);
        oor_next      = !(sel_col < col_lim) || !(r1 < row_lim);
        last_row_next = (r1 < row_lim) ? r1[RW-1:0] : row_cap[RW-1:0];
      end
      OP_UP, OP_DOWN: begin
        sel_row       = (op_r == OP_DOWN) ? r1 : r0;
        range_mode    = 1'b1;
        need_read     = (sel_row < row_lim) && (c0 < col_lim);
        oor_next      = !(sel_row < row_lim) || !(c1 < col_lim);
        first_row     = sel_row[RW-1:0];
        last_row_next = sel_row[RW-1:0];
      end
      default: ;
    endcase
    for (int i = 0; i < MAX_COLUMNS; i++) begin
      if (range_mode) begin
        mask_next[i] = (DIV_W'(i) >= c0) && (DIV_W'(i) <= c1) && (DIV_W'(i) < col_lim);
      end else begin
        mask_next[i] = (DIV_W'(i) == sel_col);
      end
    end
  end

  assign status.need_read = need_read;

  // Scan registers
  logic [RW-1:0]          cur_row;
  logic [RW-1:0]          last_row;
  logic [MAX_COLUMNS-1:0] mask;
  logic                   oor_r;
  logic                   hit_acc;
  logic [MAX_COLUMNS-1:0] rd_data;
  logic                   row_hit;

  assign row_hit          = |(rd_data & mask);
  assign status.scan_last = (cur_row == last_row);

  always_ff @(posedge clk) begin
    if (cmd.plan) begin
      cur_row  <= first_row;
      last_row <= last_row_next;
      mask     <= mask_next;
      oor_r    <= oor_next;
      hit_acc  <= 1'b0;
    end else if (cmd.eval) begin
      hit_acc <= hit_acc | row_hit;
      if (!status.scan_last) begin
        cur_row <= cur_row + 1'b1;
      end
    end
  end

  // Clearing pass over all rows after reset
  logic [RW-1:0] clear_row;

  always_ff @(posedge clk) begin
    if (rst) begin
      clear_row <= '0;
    end else if (cmd.clear_step) begin
      clear_row <= clear_row + 1'b1;
    end
  end

  assign status.clear_last = (clear_row == ROW_LAST);

  // Occupancy memory: one row of cells per word
  logic [MAX_COLUMNS-1:0] mem [MAX_ROWS];
  logic                   mem_we;
  logic [RW-1:0]          mem_waddr;
  logic [MAX_COLUMNS-1:0] mem_wdata;

  always_comb begin
    mem_we    = cmd.clear_step || (cmd.eval && ((op_r == OP_SET) || (op_r == OP_CLEAR)));
    mem_waddr = cmd.clear_step ? clear_row : cur_row;
    if (cmd.clear_step) begin
      mem_wdata = '0;
    end else if (op_r == OP_SET) begin
      mem_wdata = rd_data | mask;
    end else begin
      mem_wdata = rd_data & ~mask;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (cmd.read) begin
      rd_data <= mem[cur_row];
    end
  end

  // Form the result
  logic             hit_next;
  logic             occ_next;
  logic [Y_W-1:0]   cy_next;

  always_comb begin
    hit_next = 1'b0;
    occ_next = 1'b0;
    cy_next  = '0;
    case (op_r)
      OP_PROBE: occ_next = hit_acc;
      OP_LEFT, OP_RIGHT: hit_next = hit_acc;
      OP_UP: begin
        hit_next = hit_acc;
        if (hit_acc) begin
          cy_next = Y_W'(py_r) - Y_W'(rem[LANE_R0]) + Y_W'(ts_eff);
        end
      end
      OP_DOWN: begin
        hit_next = hit_acc && (rem[LANE_R1] < landing_tolerance);
        if (hit_next) begin
          cy_next = Y_W'(py_r) - Y_W'(1) - Y_W'(rem[LANE_R1]);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      hit          <= hit_next;
      occupied     <= occ_next;
      corrected_y  <= signed'(cy_next);
      out_of_range <= oor_r;
    end
  end

  // Strobe the result for one cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.finish;
    end
  end

endmodule

[src/tgbc_ctrl.sv]
// Controller state machine sequencing clear, divide, scan and result
module tgbc_ctrl import tgbc_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  dp_status_t status,
  output ctrl_cmd_t  cmd,
  output logic       busy
);

  typedef enum logic [6:0] {
    S_CLEAR  = 7'b0000001,
    S_IDLE   = 7'b0000010,
    S_DIV    = 7'b0000100,
    S_PLAN   = 7'b0001000,
    S_READ   = 7'b0010000,
    S_EVAL   = 7'b0100000,
    S_FINISH = 7'b1000000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Advance through the request and drive datapath commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_CLEAR: begin
        cmd.clear_step = 1'b1;
        if (status.clear_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          cmd.accept = 1'b1;
          state_next = S_DIV;
        end
      end
      S_DIV: begin
        if (status.div_done) begin
          state_next = S_PLAN;
        end
      end
      S_PLAN: begin
        cmd.plan   = 1'b1;
        state_next = status.need_read ? S_READ : S_FINISH;
      end
      S_READ: begin
        cmd.read   = 1'b1;
        state_next = S_EVAL;
      end
      S_EVAL: begin
        cmd.eval   = 1'b1;
        state_next = status.scan_last ? S_FINISH : S_READ;
      end
      S_FINISH: begin
        cmd.finish = 1'b1;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  assign busy = (state != S_IDLE);

endmodule

[src/tile_grid_box_collision_top.sv]
// Top level of the tile grid box collision block
// A request is taken when start is high and busy is low. After reset the block
// clears the occupancy map, one row per cycle, with busy high. Each request then
// runs the 17-step bit-serial divide by the tile size and then reads map rows
// one at a time through the single memory read port (one row for set, clear,
// probe, up and down; up to the rows the box spans for left and right; none
// when the addressed cells lie off the map).
// The result appears for exactly one cycle with done high; the receiver cannot
// stall it, and a new request may be taken in that same cycle.
`include "assert_macros.svh"
module tile_grid_box_collision_top import tgbc_pkg::*; #(
  parameter int MAX_COLUMNS = 64,
  parameter int MAX_ROWS    = 64
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  logic [2:0]            operation,
  input  logic [POS_W-1:0]      pos_x,
  input  logic [POS_W-1:0]      pos_y,
  input  logic [SIZE_W-1:0]     size_x,
  input  logic [SIZE_W-1:0]     size_y,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output logic                  done,
  output logic                  hit,
  output logic signed [Y_W-1:0] corrected_y,
  output logic                  occupied,
  output logic                  out_of_range
);

  ctrl_cmd_t  cmd;
  dp_status_t status;

  tgbc_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .status (status),
    .cmd    (cmd),
    .busy   (busy)
  );

  tgbc_datapath #(
    .MAX_COLUMNS (MAX_COLUMNS),
    .MAX_ROWS    (MAX_ROWS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .operation    (operation),
    .pos_x        (pos_x),
    .pos_y        (pos_y),
    .size_x       (size_x),
    .size_y       (size_y),
    .cmd          (cmd),
    .status       (status),
    .done         (done),
    .hit          (hit),
    .corrected_y  (corrected_y),
    .occupied     (occupied),
    .out_of_range (out_of_range)
  );

  // Checks
  `ASSERT_NEXT(a_accept_busy, clk, rst, start && !busy, busy)
  `ASSERT_NEXT(a_finish_done, clk, rst, cmd.finish, done)
  `ASSERT_ALWAYS(a_done_idle, clk, rst, !done || !busy)
  `ASSERT_ALWAYS(a_probe_no_hit, clk, rst, !(done && occupied && hit))

endmodule

[tb/tb_tile_grid_box_collision_top.sv]
// Testbench for the tile grid box collision top level: directed table, then random phases
`timescale 1ns / 100ps
module tb_tile_grid_box_collision_top;
  import tgbc_pkg::*;

  localparam int COLS = 64;
  localparam int ROWS = 64;
  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam int TAIL_CYCLES = 300;
  localparam logic [2:0] OP_NONE = 3'd7;

  typedef struct packed {
    logic        hit;
    logic [16:0] corr_y;
    logic        occupied;
    logic        oor;
  } collision_t;

  typedef struct packed {
    logic [2:0]  op;
    logic [15:0] px;
    logic [15:0] py;
    logic [9:0]  sx;
    logic [9:0]  sy;
    logic        typed;
    collision_t  want;
  } step_t;

  typedef struct packed {
    logic [7:0]  tile;
    logic [7:0]  width;
    logic [7:0]  height;
    logic [7:0]  tol;
    int unsigned count;
    logic        gaps;
  } phase_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  start = 1'b0;
  logic                  busy;
  logic [2:0]            operation = OP_NONE;
  logic [POS_W-1:0]      pos_x = '0;
  logic [POS_W-1:0]      pos_y = '0;
  logic [SIZE_W-1:0]     size_x = '0;
  logic [SIZE_W-1:0]     size_y = '0;
  logic                  cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = CFG_TILE_SIZE;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  done;
  logic                  hit;
  logic signed [Y_W-1:0] corrected_y;
  logic                  occupied;
  logic                  out_of_range;

  // Local copy of the block state and registers
  logic [7:0] tile_edge = TILE_SIZE_RST;
  logic [6:0] cols_used = MAP_WIDTH_RST;
  logic [6:0] rows_used = MAP_HEIGHT_RST;
  logic [7:0] land_tol = LANDING_TOL_RST;
  bit         occ_map [COLS*ROWS];

  collision_t  pending_results [$];
  int unsigned requests_sent = 0;
  int unsigned results_seen = 0;
  int unsigned hit_count = 0;
  int unsigned oor_count = 0;
  int unsigned errors = 0;
  int unsigned cycle_count = 0;
  bit          gaps_on = 1'b1;

  tile_grid_box_collision_top #(
    .MAX_COLUMNS(COLS),
    .MAX_ROWS(ROWS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .operation(operation),
    .pos_x(pos_x),
    .pos_y(pos_y),
    .size_x(size_x),
    .size_y(size_y),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .done(done),
    .hit(hit),
    .corrected_y(corrected_y),
    .occupied(occupied),
    .out_of_range(out_of_range)
  );

  always #1 clk = ~clk;

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: cycle limit reached with %0d results pending", $time,
               pending_results.size());
      $display("tb_tile_grid_box_collision_top failed");
      $finish;
    end
  end

  function automatic int unsigned tile_units();
    return (tile_edge == 8'd0) ? 1 : tile_edge;
  endfunction

  function automatic int unsigned cols_eff();
    return (cols_used > COLS) ? COLS : cols_used;
  endfunction

  function automatic int unsigned rows_eff();
    return (rows_used > ROWS) ? ROWS : rows_used;
  endfunction

  // Return {outside, occupied}; cells off the map read empty
  function automatic logic [1:0] cell_read(int unsigned c, int unsigned r);
    if (c < cols_eff() && r < rows_eff())
      return {1'b0, occ_map[r*COLS + c]};
    return 2'b10;
  endfunction

  // Compute the result of one request and apply its map update
  function automatic collision_t predict_collision(logic [2:0] op, logic [15:0] px,
                                                   logic [15:0] py, logic [9:0] sx,
                                                   logic [9:0] sy);
    int unsigned ts, ux, uy, bx, by, c0, c1, r0, r1, i;
    logic [1:0]  rd;
    logic        floor_hit;
    int          top, overlap, cy;
    collision_t  res;
    ts = tile_units();
    ux = px;
    uy = py;
    bx = (sx == 10'd0) ? 1 : sx;
    by = (sy == 10'd0) ? 1 : sy;
    c0 = ux / ts;
    c1 = (ux + bx - 1) / ts;
    r0 = uy / ts;
    r1 = (uy + by - 1) / ts;
    res = '0;
    cy = 0;
    floor_hit = 1'b0;
    case (op)
      OP_SET, OP_CLEAR: begin
        rd = cell_read(c0, r0);
        if (rd[1]) res.oor = 1'b1;
        else occ_map[r0*COLS + c0] = (op == OP_SET);
      end
      OP_PROBE: begin
        rd = cell_read(c0, r0);
        res.occupied = rd[0];
        res.oor = rd[1];
      end
      OP_LEFT, OP_RIGHT: begin
        for (i = r0; i <= r1; i++) begin
          rd = cell_read((op == OP_LEFT) ? c0 : c1, i);
          res.hit |= rd[0];
          res.oor |= rd[1];
        end
      end
      OP_UP: begin
        for (i = c0; i <= c1; i++) begin
          rd = cell_read(i, r0);
          res.hit |= rd[0];
          res.oor |= rd[1];
        end
        if (res.hit) cy = int'(ts * r0 + ts);
      end
      OP_DOWN: begin
        for (i = c0; i <= c1; i++) begin
          rd = cell_read(i, r1);
          floor_hit |= rd[0];
          res.oor |= rd[1];
        end
        // Land only when the overlap into the floor row is small enough
        if (floor_hit) begin
          top = int'(ts * r1);
          overlap = int'(uy) - top + int'(by);
          if (overlap <= int'(land_tol)) begin
            res.hit = 1'b1;
            cy = top - int'(by);
          end
        end
      end
      default: ;
    endcase
    res.corr_y = cy[16:0];
    return res;
  endfunction

  // Drive one request, hold it until taken, queue its expected result
  task automatic issue_request(logic [2:0] op, logic [15:0] px, logic [15:0] py,
                               logic [9:0] sx, logic [9:0] sy, logic typed,
                               collision_t want);
    collision_t exp_res;
    while (gaps_on && $urandom_range(99) < 34) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    operation <= op;
    pos_x <= px;
    pos_y <= py;
    size_x <= sx;
    size_y <= sy;
    do @(negedge clk); while (busy);
    exp_res = predict_collision(op, px, py, sx, sy);
    if (typed) exp_res = want;
    pending_results.push_back(exp_res);
    requests_sent++;
    @(posedge clk);
  endtask

  // Hold off new requests until every result is back and the block is idle
  task automatic drain_requests();
    start <= 1'b0;
    do @(negedge clk); while (pending_results.size() != 0 || busy);
    @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [7:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      CFG_TILE_SIZE:   tile_edge = val;
      CFG_MAP_WIDTH:   cols_used = val[6:0];
      CFG_MAP_HEIGHT:  rows_used = val[6:0];
      CFG_LANDING_TOL: land_tol = val;
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic apply_settings(phase_t ph);
    drain_requests();
    write_reg(CFG_TILE_SIZE, ph.tile);
    write_reg(CFG_MAP_WIDTH, ph.width);
    write_reg(CFG_MAP_HEIGHT, ph.height);
    write_reg(CFG_LANDING_TOL, ph.tol);
    cfg_write <= 1'b0;
    gaps_on = ph.gaps;
  endtask

  // Mostly boxes near the populated corner of the map, some full-range noise
  task automatic random_request();
    logic [2:0]  op;
    logic [15:0] px, py;
    logic [9:0]  sx, sy;
    int unsigned ts, pick, span_x, span_y, lim, r, k, bottom;
    ts = tile_units();
    pick = $urandom_range(99);
    if (pick < 10) begin
      op = 3'($urandom_range(0, 7));
      px = 16'($urandom);
      py = 16'($urandom);
      sx = 10'($urandom_range(0, 1023));
      sy = 10'($urandom_range(0, 1023));
    end else begin
      pick = $urandom_range(99);
      op = (pick < 25) ? OP_SET : (pick < 33) ? OP_CLEAR : (pick < 45) ? OP_PROBE :
           (pick < 57) ? OP_LEFT : (pick < 69) ? OP_RIGHT : (pick < 81) ? OP_UP : OP_DOWN;
      if ($urandom_range(99) < 70) begin
        span_x = ts * (((cols_eff() < 10) ? cols_eff() : 10) + 1);
        span_y = ts * (((rows_eff() < 10) ? rows_eff() : 10) + 1);
      end else begin
        span_x = ts * (cols_eff() + 2);
        span_y = ts * (rows_eff() + 2);
      end
      px = 16'($urandom_range(0, span_x - 1));
      py = 16'($urandom_range(0, span_y - 1));
      lim = (3 * ts > 1023) ? 1023 : 3 * ts;
      sx = 10'(($urandom_range(99) < 5) ? $urandom_range(0, 1023) : $urandom_range(1, lim));
      sy = 10'(($urandom_range(99) < 5) ? $urandom_range(0, 1023) : $urandom_range(1, lim));
      // Place the box bottom just inside a floor row
      if (op == OP_DOWN && $urandom_range(1) == 1) begin
        r = $urandom_range(0, rows_eff() + 1);
        k = $urandom_range(1, (ts < int'(land_tol) + 2) ? ts : int'(land_tol) + 2);
        bottom = ts * r + k;
        if (bottom < sy) sy = 10'(bottom);
        py = 16'(bottom - sy);
      end
    end
    issue_request(op, px, py, sx, sy, 1'b0, '0);
  endtask

  // Compare each result against the oldest expectation
  always @(negedge clk) begin : result_check
    collision_t want;
    if (!rst && done) begin
      results_seen++;
      hit_count += hit;
      oor_count += out_of_range;
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: result with no request pending", $time);
      end else begin
        want = pending_results.pop_front();
        if (hit !== want.hit) begin
          errors++;
          $display("%0t: hit expected %0b actual %0b", $time, want.hit, hit);
        end
        if (corrected_y !== want.corr_y) begin
          errors++;
          $display("%0t: corrected_y expected %0d actual %0d", $time,
                   $signed(want.corr_y), corrected_y);
        end
        if (occupied !== want.occupied) begin
          errors++;
          $display("%0t: occupied expected %0b actual %0b", $time, want.occupied, occupied);
        end
        if (out_of_range !== want.oor) begin
          errors++;
          $display("%0t: out_of_range expected %0b actual %0b", $time, want.oor,
                   out_of_range);
        end
      end
    end
  end

  // Directed requests at reset settings (tile 24, 64 x 64 map, tolerance 4)
  step_t directed_steps [24] = '{
    '{OP_PROBE, 16'd0, 16'd0, 10'd1, 10'd1, 1'b1, '{1'b0, 17'd0, 1'b0, 1'b0}},
    '{OP_PROBE, 16'd65535, 16'd65535, 10'd1, 10'd1, 1'b1, '{1'b0, 17'd0, 1'b0, 1'b1}},
    '{OP_SET, 16'd0, 16'd0, 10'd1, 10'd1, 1'b1, '{1'b0, 17'd0, 1'b0, 1'b0}},
    '{OP_PROBE, 16'd0, 16'd0, 10'd1, 10'd1, 1'b1, '{1'b0, 17'd0, 1'b1, 1'b0}},
    '{OP_SET, 16'd1512, 16'd1512, 10'd1, 10'd1, 1'b1, '{1'b0, 17'd0, 1'b0, 1'b0}},
    '{OP_PROBE, 16'd1535, 16'd1535, 10'd1, 10'd1, 1'b1, '{1'b0, 17'd0, 1'b1, 1'b0}},
    '{OP_SET, 16'd1536, 16'd0, 10'd1, 10'd1, 1'b1, '{1'b0, 17'd0, 1'b0, 1'b1}},
    '{OP_CLEAR, 16'd65535, 16'd65535, 10'd1, 10'd1, 1'b1, '{1'b0, 17'd0, 1'b0, 1'b1}},
    '{OP_UP, 16'd0, 16'd0, 10'd0, 10'd0, 1'b1, '{1'b1, 17'd24, 1'b0, 1'b0}},
    '{OP_DOWN, 16'd0, 16'd0, 10'd1, 10'd4, 1'b1, '{1'b1, 17'h1FFFC, 1'b0, 1'b0}},
    '{OP_DOWN, 16'd0, 16'd0, 10'd1, 10'd5, 1'b1, '{1'b0, 17'd0, 1'b0, 1'b0}},
    '{OP_NONE, 16'd65535, 16'd65535, 10'd1023, 10'd1023, 1'b1, '{1'b0, 17'd0, 1'b0, 1'b0}},
    '{OP_LEFT, 16'd0, 16'd0, 10'd1023, 10'd1023, 1'b0, '0},
    '{OP_RIGHT, 16'd1500, 16'd1500, 10'd1023, 10'd1023, 1'b0, '0},
    '{OP_RIGHT, 16'd1490, 16'd1500, 10'd22, 10'd40, 1'b0, '0},
    '{OP_UP, 16'd1512, 16'd1512, 10'd0, 10'd0, 1'b0, '0},
    '{OP_DOWN, 16'd1512, 16'd1488, 10'd10, 10'd26, 1'b0, '0},
    '{OP_LEFT, 16'd65535, 16'd0, 10'd1023, 10'd1, 1'b0, '0},
    '{OP_UP, 16'd0, 16'd65535, 10'd1, 10'd1023, 1'b0, '0},
    '{OP_CLEAR, 16'd0, 16'd0, 10'd1, 10'd1, 1'b1, '{1'b0, 17'd0, 1'b0, 1'b0}},
    '{OP_PROBE, 16'd23, 16'd23, 10'd1, 10'd1, 1'b1, '{1'b0, 17'd0, 1'b0, 1'b0}},
    '{OP_DOWN, 16'd65535, 16'd65535, 10'd1023, 10'd1023, 1'b0, '0},
    '{OP_SET, 16'd0, 16'd1512, 10'd1, 10'd1, 1'b1, '{1'b0, 17'd0, 1'b0, 1'b0}},
    '{OP_LEFT, 16'd0, 16'd1500, 10'd1, 10'd1023, 1'b0, '0}
  };

  // Register settings per phase: reset values, small maps, extremes, empty maps
  phase_t phases [8] = '{
    '{8'd24, 8'd64, 8'd64, 8'd4, 100, 1'b1},
    '{8'd8, 8'd10, 8'd7, 8'd2, 110, 1'b1},
    '{8'd1, 8'd16, 8'd16, 8'd0, 100, 1'b1},
    '{8'd255, 8'd255, 8'd127, 8'd255, 100, 1'b1},
    '{8'd0, 8'd5, 8'd3, 8'd1, 100, 1'b1},
    '{8'd16, 8'd0, 8'd4, 8'd8, 40, 1'b1},
    '{8'd6, 8'd64, 8'd0, 8'd3, 30, 1'b1},
    '{8'd12, 8'd20, 8'd20, 8'd6, 150, 1'b0}
  };

  initial begin : stimulus
    int i, n;
    foreach (occ_map[j]) occ_map[j] = 1'b0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    // Wait out the map clearing pass
    do @(negedge clk); while (busy);
    @(posedge clk);

    for (i = 0; i < 24; i++)
      issue_request(directed_steps[i].op, directed_steps[i].px, directed_steps[i].py,
                    directed_steps[i].sx, directed_steps[i].sy, directed_steps[i].typed,
                    directed_steps[i].want);

    for (i = 0; i < 8; i++) begin
      apply_settings(phases[i]);
      for (n = 0; n < int'(phases[i].count); n++) begin
        if (i == 1 && n == 40) drain_requests();
        random_request();
      end
    end

    drain_requests();
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("Sent %0d requests over %0d register settings; checked %0d results", requests_sent,
             8, results_seen);
    $display("Saw %0d box hits and %0d off-map accesses", hit_count, oor_count);
    if (errors == 0) begin
      $display("tb_tile_grid_box_collision_top passed");
    end else begin
      $display("%0d mismatches", errors);
      $display("tb_tile_grid_box_collision_top failed");
    end
    $finish;
  end

endmodule

[filelist.f]
+incdir+src
src/tgbc_pkg.sv
src/tgbc_divider.sv
src/tgbc_datapath.sv
src/tgbc_ctrl.sv
src/tile_grid_box_collision_top.sv
tb/tb_tile_grid_box_collision_top.sv
